>>> hdl/clp_pkg.sv
// clp_pkg: shared constants, request/result types and helpers for the
// cache line liveness profiler. No dependencies.
package clp_pkg;

    localparam int unsigned SET_COUNT  = 256;
    localparam int unsigned WAY_COUNT  = 8;
    localparam int unsigned TIME_BITS  = 48;
    localparam int unsigned LINE_COUNT = SET_COUNT * WAY_COUNT;
    localparam int unsigned LINE_AW    = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

    localparam int unsigned NUM_EVENTS = 7;
    localparam int unsigned NUM_BINS   = 7;

    localparam logic [4:0] SEL_EVT_LAST = 5'd6;
    localparam logic [4:0] SEL_RD_FIRST = 5'd7;
    localparam logic [4:0] SEL_RD_LAST  = 5'd13;
    localparam logic [4:0] SEL_WB_FIRST = 5'd14;
    localparam logic [4:0] SEL_WB_LAST  = 5'd20;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [2:0] {
        K_HIT,
        K_MISS,
        K_SEND_WB,
        K_RECV_WB,
        K_EVICT,
        K_INVAL,
        K_SUB_MISS,
        K_QUERY
    } t_kind;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [LINE_AW-1:0]   t_line_addr;

    typedef struct packed {
        logic       on;
        t_time      last_time;
        logic [7:0] reads;
        logic [7:0] writebacks;
    } t_line;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  set_index;
        logic [2:0]  way;
        logic [47:0] now;
        logic [4:0]  stat_select;
    } t_request;

    typedef struct packed {
        logic [47:0] interval_cycles;
        logic        interval_counted_on;
        logic [63:0] cycles_on_total;
        logic [63:0] cycles_off_total;
        logic [63:0] cycles_off_from_start;
        logic [2:0]  read_bin;
        logic [2:0]  writeback_bin;
        logic        bins_valid;
        logic [31:0] stat_value;
        logic        bad_event;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic       count_en;
        logic [2:0] kind;
        logic       add_en;
        logic       to_on;
        logic       from_start;
        t_time      interval;
        logic       evict;
        logic [2:0] rbin;
        logic [2:0] wbin;
        logic       query;
        logic [4:0] sel;
    } t_stat_cmd;

    function automatic logic [2:0] count_bin(input logic [7:0] c);
        logic [2:0] bin;
        if (c == 8'd0)        bin = 3'd0;
        else if (c == 8'd1)   bin = 3'd1;
        else if (c <= 8'd3)   bin = 3'd2;
        else if (c <= 8'd7)   bin = 3'd3;
        else if (c <= 8'd15)  bin = 3'd4;
        else if (c <= 8'd127) bin = 3'd5;
        else                  bin = 3'd6;
        return bin;
    endfunction

endpackage

>>> hdl/clp_line_mem.sv
// clp_line_mem: per-line metadata memory, one read and one write port,
// registered read data, zero-fill sweep after reset. Uses clp_pkg.
module clp_line_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  clp_pkg::t_line_addr i_rd_addr,
    output clp_pkg::t_line    o_rd_data,
    input  logic              i_wr_en,
    input  clp_pkg::t_line_addr i_wr_addr,
    input  clp_pkg::t_line    i_wr_data,
    output logic              o_clearing
);
    import clp_pkg::*;

    t_line      r_mem [LINE_COUNT];
    t_line      r_rd_data;
    logic       r_clearing;
    t_line_addr r_clr_addr;

    logic       w_we;
    t_line_addr w_waddr;
    t_line      w_wdata;

    assign w_we    = r_clearing | i_wr_en;
    assign w_waddr = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_wdata = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // zero-fill sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LINE_AW'(LINE_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + LINE_AW'(1);
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

>>> hdl/clp_stats.sv
// clp_stats: cycle totals, event counters and read/writeback histograms,
// plus the query read mux. Uses clp_pkg.
module clp_stats (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clp_pkg::t_stat_cmd i_cmd,
    output logic [63:0]        o_on_total,
    output logic [63:0]        o_off_total,
    output logic [63:0]        o_off_start,
    output logic [31:0]        o_stat_value
);
    import clp_pkg::*;

    logic [31:0] r_evt     [NUM_EVENTS];
    logic [31:0] r_rd_hist [NUM_BINS];
    logic [31:0] r_wb_hist [NUM_BINS];
    logic [63:0] r_on;
    logic [63:0] r_off;
    logic [63:0] r_start;
    logic [31:0] r_stat;

    logic [63:0] w_iv;
    logic [31:0] w_query;

    assign w_iv = 64'(i_cmd.interval);

    always_comb begin
        w_query = '0;
        if (i_cmd.sel <= SEL_EVT_LAST) begin
            w_query = r_evt[i_cmd.sel[2:0]];
        end else if (i_cmd.sel <= SEL_RD_LAST) begin
            w_query = r_rd_hist[3'(i_cmd.sel - SEL_RD_FIRST)];
        end else if (i_cmd.sel <= SEL_WB_LAST) begin
            w_query = r_wb_hist[3'(i_cmd.sel - SEL_WB_FIRST)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_EVENTS; i++) begin
                r_evt[i] <= '0;
            end
            for (int i = 0; i < NUM_BINS; i++) begin
                r_rd_hist[i] <= '0;
                r_wb_hist[i] <= '0;
            end
            r_on    <= '0;
            r_off   <= '0;
            r_start <= '0;
            r_stat  <= '0;
        end else if (i_cmd.valid) begin
            for (int i = 0; i < NUM_EVENTS; i++) begin
                if (i_cmd.count_en && (i_cmd.kind == 3'(i))) begin
                    r_evt[i] <= r_evt[i] + 32'd1;
                end
            end
            for (int i = 0; i < NUM_BINS; i++) begin
                if (i_cmd.evict && (i_cmd.rbin == 3'(i))) begin
                    r_rd_hist[i] <= r_rd_hist[i] + 32'd1;
                end
                if (i_cmd.evict && (i_cmd.wbin == 3'(i))) begin
                    r_wb_hist[i] <= r_wb_hist[i] + 32'd1;
                end
            end
            if (i_cmd.add_en) begin
                if (i_cmd.to_on) begin
                    r_on <= r_on + w_iv;
                end else begin
                    r_off <= r_off + w_iv;
                end
                if (i_cmd.from_start) begin
                    r_start <= r_start + w_iv;
                end
            end
            r_stat <= i_cmd.query ? w_query : '0;
        end
    end

    assign o_on_total   = r_on;
    assign o_off_total  = r_off;
    assign o_off_start  = r_start;
    assign o_stat_value = r_stat;

endmodule

>>> hdl/cache_line_liveness_profiler.sv
// cache_line_liveness_profiler: top level, request sequencer around the line
// metadata memory and the statistics unit. Uses clp_pkg, clp_line_mem, clp_stats.
//
//  channel   | signals                     | handshake
//  ----------+-----------------------------+-----------------------------------
//  request   | start, i_request, busy      | taken when start && !busy
//  result    | o_done, o_result            | valid for the one cycle o_done is high
//
// each request passes through line memory read, read-modify-write of the
// line, then the 64-bit total update; result shows the cycle after that
// after reset busy stays high while the line memory is zeroed
// busy is high from acceptance until the result cycle; results cannot be held off
module cache_line_liveness_profiler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  clp_pkg::t_request i_request,
    output logic              busy,
    output logic              o_done,
    output clp_pkg::t_result  o_result
);
    import clp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_ACC
    } t_state;

    t_state     r_state;
    logic       r_done;
    t_request   r_req;
    t_line_addr r_addr;
    logic       r_line_ev;
    logic       r_bad;
    t_time      r_iv;
    logic       r_to_on;
    logic       r_from_start;
    logic       r_evict;
    logic [2:0] r_rbin;
    logic [2:0] r_wbin;

    logic       w_accept;
    logic       w_clearing;
    logic       w_in_range;
    t_line_addr w_addr;
    t_line      w_line;
    t_line      n_line;
    t_time      w_now;
    t_time      w_iv;
    logic       w_hit_like;
    logic       w_to_on;
    logic       w_from_start;
    logic       w_is_evict;
    t_stat_cmd  w_cmd;
    logic [63:0] w_on_total;
    logic [63:0] w_off_total;
    logic [63:0] w_off_start;
    logic [31:0] w_stat_value;

    assign busy     = w_clearing | (r_state != S_IDLE);
    assign w_accept = start & ~busy;

    assign w_in_range = (32'(i_request.set_index) < SET_COUNT) &&
                        (32'(i_request.way) < WAY_COUNT);
    assign w_addr = LINE_AW'(32'(i_request.set_index) * WAY_COUNT + 32'(i_request.way));

    // line update
    always_comb begin
        w_now        = TIME_BITS'(r_req.now);
        w_iv         = w_now - w_line.last_time;
        w_hit_like   = (r_req.kind == K_HIT) || (r_req.kind == K_SEND_WB);
        w_to_on      = w_hit_like && w_line.on;
        w_from_start = !w_to_on && (w_line.last_time == '0);
        w_is_evict   = (r_req.kind == K_EVICT);

        n_line           = w_line;
        n_line.on        = w_hit_like || (r_req.kind == K_RECV_WB);
        n_line.last_time = w_now;
        if (w_is_evict) begin
            n_line.reads      = '0;
            n_line.writebacks = '0;
        end else begin
            if ((r_req.kind == K_HIT) && (w_line.reads != COUNT_MAX)) begin
                n_line.reads = w_line.reads + 8'd1;
            end
            if ((r_req.kind == K_RECV_WB) && (w_line.writebacks != COUNT_MAX)) begin
                n_line.writebacks = w_line.writebacks + 8'd1;
            end
        end
    end

    clp_line_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_addr  (w_addr),
        .o_rd_data  (w_line),
        .i_wr_en    ((r_state == S_CALC) && r_line_ev),
        .i_wr_addr  (r_addr),
        .i_wr_data  (n_line),
        .o_clearing (w_clearing)
    );

    always_comb begin
        w_cmd            = '0;
        w_cmd.valid      = (r_state == S_ACC);
        w_cmd.count_en   = r_line_ev || r_bad;
        w_cmd.kind       = r_req.kind;
        w_cmd.add_en     = r_line_ev;
        w_cmd.to_on      = r_to_on;
        w_cmd.from_start = r_from_start;
        w_cmd.interval   = r_iv;
        w_cmd.evict      = r_evict;
        w_cmd.rbin       = r_rbin;
        w_cmd.wbin       = r_wbin;
        w_cmd.query      = (r_req.kind == K_QUERY);
        w_cmd.sel        = r_req.stat_select;
    end

    clp_stats u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_on_total   (w_on_total),
        .o_off_total  (w_off_total),
        .o_off_start  (w_off_start),
        .o_stat_value (w_stat_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req     <= i_request;
                        r_addr    <= w_addr;
                        r_line_ev <= w_in_range && (i_request.kind < K_SUB_MISS);
                        r_bad     <= (i_request.kind == K_SUB_MISS);
                        r_state   <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_iv         <= r_line_ev ? w_iv : '0;
                    r_to_on      <= r_line_ev && w_to_on;
                    r_from_start <= r_line_ev && w_from_start;
                    r_evict      <= r_line_ev && w_is_evict;
                    r_rbin       <= (r_line_ev && w_is_evict) ? count_bin(w_line.reads) : 3'd0;
                    r_wbin       <= (r_line_ev && w_is_evict) ?
                                    count_bin(w_line.writebacks) : 3'd0;
                    r_state      <= S_ACC;
                end
                S_ACC: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;

    always_comb begin
        o_result                       = '0;
        o_result.interval_cycles       = 48'(r_iv);
        o_result.interval_counted_on   = r_to_on;
        o_result.cycles_on_total       = w_on_total;
        o_result.cycles_off_total      = w_off_total;
        o_result.cycles_off_from_start = w_off_start;
        o_result.read_bin              = r_rbin;
        o_result.writeback_bin         = r_wbin;
        o_result.bins_valid            = r_evict;
        o_result.stat_value            = w_stat_value;
        o_result.bad_event             = r_bad;
    end

endmodule

>>> hdl/clp_checker.sv
// clp_checker: port-level checks on request/result timing and result fields
// of cache_line_liveness_profiler, attached by bind. Uses clp_pkg.
module clp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input clp_pkg::t_result o_result
);
    import clp_pkg::*;

    a_done_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 3))
        else $error("result without a request three cycles before");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a request");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe high two cycles in a row");

    a_bad_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.bad_event) |->
            (o_result.interval_cycles == '0 && !o_result.bins_valid &&
             !o_result.interval_counted_on && o_result.stat_value == '0))
        else $error("sub-block miss result carries line data");

endmodule

bind cache_line_liveness_profiler clp_checker u_clp_checker (.*);
